### rtl/core/gap_buffer_text_editor_defines.svh
// ----------------------------------------------------------------------------
// gap buffer text editor assertion macros
// shared property forms for the editor's concurrent checks
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_EDITOR_DEFINES_SVH
`define GAP_BUFFER_TEXT_EDITOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GBTE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GBTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gbte_pkg.sv
// ----------------------------------------------------------------------------
// gbte_pkg
// command and status codes of the gap buffer text editor
// ----------------------------------------------------------------------------
package gbte_pkg;

    localparam int POS_W    = 11;
    localparam int CHAR_W   = 8;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_DELETE    = 3'd1,
        FUNC_BACKSPACE = 3'd2,
        FUNC_MOVE      = 3'd3,
        FUNC_REPLACE   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

### rtl/core/gap_buffer_text_editor.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_editor
// two-stack gap buffer line editor with a cursor, one result per command
// ----------------------------------------------------------------------------
// The text lives in one single-port store of CAPACITY characters: text before
// the cursor fills it from the bottom, text after the cursor from the top.
// A command is taken only while the block is idle; every command then makes
// one result transaction. Insert, delete, backspace, an out-of-range move and
// unused codes pass from accept to the next accept through the execute state,
// the reads of the characters on both sides of the cursor through the
// registered store port (S_VIEW_B, S_VIEW_A, S_VIEW_C), the load of the result
// register and the idle state that takes the next command. A move in range
// adds a read then a write on the store port per character carried across
// the gap, and find and replace adds a read, and a write where the character
// matches, per stored character visited. The load waits for as long as an
// earlier result is still stalled. The result register lets a new command
// start while the previous result is still stalled.
// ----------------------------------------------------------------------------
`include "gap_buffer_text_editor_defines.svh"

module gap_buffer_text_editor
    import gbte_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [CHAR_W-1:0]   char_value,
    input  logic [POS_W-1:0]    position,
    input  logic [CHAR_W-1:0]   replace_char,
    // result channel
    output logic                res_valid,
    input  logic                res_stall,
    output logic [STATUS_W-1:0] status,
    output logic [POS_W-1:0]    cursor_pos,
    output logic [POS_W-1:0]    after_count,
    output logic [CHAR_W-1:0]   char_before,
    output logic [CHAR_W-1:0]   char_after
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int SUM_W = LEN_W + 1;
    localparam int CMP_W = (SUM_W > POS_W) ? SUM_W : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE_RD,
        S_MOVE_WR,
        S_REPL_RD,
        S_REPL_WR,
        S_VIEW_B,
        S_VIEW_A,
        S_VIEW_C,
        S_DONE
    } state_t;

    // control and working registers
    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CHAR_W-1:0]  repl_reg, repl_next;
    logic [LEN_W-1:0]   before_reg, before_next;
    logic [LEN_W-1:0]   after_reg, after_next;
    status_t            st_reg, st_next;
    logic [AW-1:0]      rp_addr_reg, rp_addr_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [CHAR_W-1:0]  cb_reg, cb_next;
    logic [CHAR_W-1:0]  ca_reg, ca_next;

    // result register
    logic               res_valid_reg, res_valid_next;
    status_t            status_reg, status_next;
    logic [POS_W-1:0]   cursor_pos_reg, cursor_pos_next;
    logic [POS_W-1:0]   after_count_reg, after_count_next;
    logic [CHAR_W-1:0]  char_before_reg, char_before_next;
    logic [CHAR_W-1:0]  char_after_reg, char_after_next;

    // text store
    logic [CHAR_W-1:0]  text_mem [CAPACITY];
    logic [CHAR_W-1:0]  rdata_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CHAR_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // derived lengths and addresses
    logic [SUM_W-1:0]   total;
    logic [LEN_W-1:0]   top;
    logic [LEN_W-1:0]   top_m1;
    logic [LEN_W-1:0]   before_m1;
    logic [LEN_W-1:0]   rp_addr_inc;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   before_ext;
    logic [CMP_W-1:0]   after_ext;
    logic [CMP_W-1:0]   total_ext;

    assign total       = SUM_W'(before_reg) + SUM_W'(after_reg);
    assign top         = LEN_W'(CAPACITY) - after_reg;
    assign top_m1      = top - LEN_W'(1);
    assign before_m1   = before_reg - LEN_W'(1);
    assign rp_addr_inc = LEN_W'(rp_addr_reg) + LEN_W'(1);
    assign pos_ext     = CMP_W'(pos_reg);
    assign before_ext  = CMP_W'(before_reg);
    assign after_ext   = CMP_W'(after_reg);
    assign total_ext   = CMP_W'(total);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        ch_next          = ch_reg;
        pos_next         = pos_reg;
        repl_next        = repl_reg;
        before_next      = before_reg;
        after_next       = after_reg;
        st_next          = st_reg;
        rp_addr_next     = rp_addr_reg;
        rem_next         = rem_reg;
        cb_next          = cb_reg;
        ca_next          = ca_reg;
        res_valid_next   = res_valid_reg && res_stall;
        status_next      = status_reg;
        cursor_pos_next  = cursor_pos_reg;
        after_count_next = after_count_reg;
        char_before_next = char_before_reg;
        char_after_next  = char_after_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next  = func_t'(func);
                    ch_next    = char_value;
                    pos_next   = position;
                    repl_next  = replace_char;
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_VIEW_B;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (total >= SUM_W'(CAPACITY))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = before_reg[AW-1:0];
                            mem_wdata   = ch_reg;
                            before_next = before_reg + LEN_W'(1);
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (after_reg == '0)
                            st_next = ST_EMPTY;
                        else
                            after_next = after_reg - LEN_W'(1);
                    end
                    FUNC_BACKSPACE:
                    begin
                        if (before_reg == '0)
                            st_next = ST_EMPTY;
                        else
                            before_next = before_m1;
                    end
                    FUNC_MOVE:
                    begin
                        if (pos_ext > total_ext)
                            st_next = ST_RANGE;
                        else
                            state_next = S_MOVE_RD;
                    end
                    FUNC_REPLACE:
                    begin
                        rem_next     = total[LEN_W-1:0];
                        rp_addr_next = (before_reg != '0) ? '0 : top[AW-1:0];
                        state_next   = S_REPL_RD;
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end

            // carry one character across the gap: read the source
            S_MOVE_RD:
            begin
                if (before_ext == pos_ext)
                begin
                    state_next = S_VIEW_B;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (before_ext > pos_ext) ? before_m1[AW-1:0] : top[AW-1:0];
                    state_next = S_MOVE_WR;
                end
            end

            // write it on the other side and adjust both lengths
            S_MOVE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                if (before_ext > pos_ext)
                begin
                    mem_waddr   = top_m1[AW-1:0];
                    before_next = before_m1;
                    after_next  = after_reg + LEN_W'(1);
                end
                else
                begin
                    mem_waddr   = before_reg[AW-1:0];
                    before_next = before_reg + LEN_W'(1);
                    after_next  = after_reg - LEN_W'(1);
                end
                state_next = S_MOVE_RD;
            end

            // walk every stored character, skipping the gap
            S_REPL_RD:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_VIEW_B;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rp_addr_reg;
                    state_next = S_REPL_WR;
                end
            end

            S_REPL_WR:
            begin
                if (rdata_reg == ch_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rp_addr_reg;
                    mem_wdata = repl_reg;
                end
                if (rp_addr_inc == before_reg && after_reg != '0)
                    rp_addr_next = top[AW-1:0];
                else
                    rp_addr_next = rp_addr_inc[AW-1:0];
                rem_next   = rem_reg - LEN_W'(1);
                state_next = S_REPL_RD;
            end

            // read the characters on both sides of the cursor
            S_VIEW_B:
            begin
                mem_re     = 1'b1;
                mem_raddr  = before_m1[AW-1:0];
                state_next = S_VIEW_A;
            end

            S_VIEW_A:
            begin
                cb_next    = (before_reg != '0) ? rdata_reg : '0;
                mem_re     = 1'b1;
                mem_raddr  = top[AW-1:0];
                state_next = S_VIEW_C;
            end

            S_VIEW_C:
            begin
                ca_next    = (after_reg != '0) ? rdata_reg : '0;
                state_next = S_DONE;
            end

            // load the result register once it is free
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next   = 1'b1;
                    status_next      = st_reg;
                    cursor_pos_next  = before_ext[POS_W-1:0];
                    after_count_next = after_ext[POS_W-1:0];
                    char_before_next = cb_reg;
                    char_after_next  = ca_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            before_reg      <= '0;
            after_reg       <= '0;
            res_valid_reg   <= 1'b0;
            func_reg        <= FUNC_INSERT;
            st_reg          <= ST_OK;
            rem_reg         <= '0;
            rp_addr_reg     <= '0;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            before_reg      <= before_next;
            after_reg       <= after_next;
            res_valid_reg   <= res_valid_next;
            func_reg        <= func_next;
            st_reg          <= st_next;
            rem_reg         <= rem_next;
            rp_addr_reg     <= rp_addr_next;
            status_reg      <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg          <= ch_next;
        pos_reg         <= pos_next;
        repl_reg        <= repl_next;
        cb_reg          <= cb_next;
        ca_reg          <= ca_next;
        cursor_pos_reg  <= cursor_pos_next;
        after_count_reg <= after_count_next;
        char_before_reg <= char_before_next;
        char_after_reg  <= char_after_next;
    end

    // text store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            text_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= text_mem[mem_raddr];
    end

    // ports
    assign cmd_stall   = (state_reg != S_IDLE);
    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign cursor_pos  = cursor_pos_reg;
    assign after_count = after_count_reg;
    assign char_before = char_before_reg;
    assign char_after  = char_after_reg;

    // checks
    `GBTE_ASSERT_IMPLY(a_len_fits, 1'b1, total <= SUM_W'(CAPACITY), "text exceeds capacity")
    `GBTE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "not busy after accept")
    `GBTE_ASSERT_NEXT(a_move_keeps_total, state_reg == S_MOVE_WR, total == $past(total), "move changed text length")
    `GBTE_ASSERT_IMPLY(a_result_from_done, $rose(res_valid_reg), $past(state_reg == S_DONE), "result without command")

endmodule

### tb/gap_buffer_text_editor_checker.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_editor_checker
// predicts every editor result and compares it with the result channel
// ----------------------------------------------------------------------------
// A shadow gap buffer is updated on each accepted command transaction. The
// line view it gives is queued and compared field by field with the next
// result transaction. Mismatches, the number of views still owed and the
// shadow line length and cursor are handed to the testbench top.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor_checker
    import gbte_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [CHAR_W-1:0]   char_value,
    input  logic [POS_W-1:0]    position,
    input  logic [CHAR_W-1:0]   replace_char,
    input  logic                res_valid,
    input  logic                res_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [POS_W-1:0]    cursor_pos,
    input  logic [POS_W-1:0]    after_count,
    input  logic [CHAR_W-1:0]   char_before,
    input  logic [CHAR_W-1:0]   char_after,
    output int                  mismatch_count,
    output int                  views_pending,
    output int                  text_length,
    output int                  cursor_at
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  after_count;
        logic [CHAR_W-1:0] char_before;
        logic [CHAR_W-1:0] char_after;
    } line_view_t;

    // shadow gap buffer: head grows up from 0, tail grows down from the top
    logic [CHAR_W-1:0] shadow_chars [CAPACITY];
    int                head_len = 0;
    int                tail_len = 0;
    int                mismatches = 0;
    int                owed = 0;
    line_view_t        owed_views[$];

    assign mismatch_count = mismatches;
    assign views_pending  = owed;
    assign text_length    = head_len + tail_len;
    assign cursor_at      = head_len;

    // apply one editing command to the shadow buffer and return the new view
    function automatic line_view_t apply_edit(input logic [FUNC_W-1:0]  op,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [POS_W-1:0]  pos,
                                              input logic [CHAR_W-1:0] repl);
        line_view_t view;
        status_t    st;
        int         target;
        int         idx;
        st = ST_OK;
        target = pos;
        case (op)
            FUNC_INSERT:
            begin
                if (head_len + tail_len >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    shadow_chars[head_len] = ch;
                    head_len++;
                end
            end
            FUNC_DELETE:
            begin
                if (tail_len == 0)
                    st = ST_EMPTY;
                else
                    tail_len--;
            end
            FUNC_BACKSPACE:
            begin
                if (head_len == 0)
                    st = ST_EMPTY;
                else
                    head_len--;
            end
            FUNC_MOVE:
            begin
                if (target > head_len + tail_len)
                    st = ST_RANGE;
                else
                begin
                    // carry characters across the gap one at a time
                    while (head_len > target)
                    begin
                        shadow_chars[CAPACITY - tail_len - 1] = shadow_chars[head_len - 1];
                        head_len--;
                        tail_len++;
                    end
                    while (head_len < target)
                    begin
                        shadow_chars[head_len] = shadow_chars[CAPACITY - tail_len];
                        head_len++;
                        tail_len--;
                    end
                end
            end
            FUNC_REPLACE:
            begin
                for (idx = 0; idx < head_len; idx++)
                    if (shadow_chars[idx] == ch)
                        shadow_chars[idx] = repl;
                for (idx = CAPACITY - tail_len; idx < CAPACITY; idx++)
                    if (shadow_chars[idx] == ch)
                        shadow_chars[idx] = repl;
            end
            default:
            begin
                // unused codes leave the line alone
            end
        endcase
        view.status      = st;
        view.cursor_pos  = POS_W'(head_len);
        view.after_count = POS_W'(tail_len);
        view.char_before = (head_len > 0) ? shadow_chars[head_len - 1] : '0;
        view.char_after  = (tail_len > 0) ? shadow_chars[CAPACITY - tail_len] : '0;
        return view;
    endfunction

    task automatic check_field(input string label, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // compare result transactions, then predict from command transactions
    always @(posedge clk or negedge rst_n)
    begin
        line_view_t want;
        if (!rst_n)
        begin
            head_len = 0;
            tail_len = 0;
            owed_views.delete();
            owed = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (owed_views.size() == 0)
                begin
                    $display("%0t: result transaction with no command outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    want = owed_views.pop_front();
                    check_field("status", POS_W'(want.status), POS_W'(status));
                    check_field("cursor_pos", want.cursor_pos, cursor_pos);
                    check_field("after_count", want.after_count, after_count);
                    check_field("char_before", POS_W'(want.char_before), POS_W'(char_before));
                    check_field("char_after", POS_W'(want.char_after), POS_W'(char_after));
                end
            end
            if (cmd_valid && !cmd_stall)
                owed_views.push_back(apply_edit(func, char_value, position, replace_char));
            owed = owed_views.size();
        end
    end

endmodule

### tb/gap_buffer_text_editor_tb.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_editor_tb
// command stimulus and verdict for the gap buffer text editor
// ----------------------------------------------------------------------------
// Directed commands cover empty-line errors, moves to the ends and past them,
// replace and unused codes. Random editing on short lines then runs under
// several idling patterns, one of them with a long result hold-off, and a
// last phase fills the line to capacity and edits it there. The checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor_tb;

    import gbte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP            = 1024;
    localparam int PHASE_ITEMS    = 160;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 20000;

    // command codes with no operation behind them
    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_value;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   replace_char;
    logic                res_valid;
    logic                res_stall;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    cursor_pos;
    logic [POS_W-1:0]    after_count;
    logic [CHAR_W-1:0]   char_before;
    logic [CHAR_W-1:0]   char_after;

    int mismatch_count;
    int views_pending;
    int text_length;
    int cursor_at;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_pending = 1'b0;

    gap_buffer_text_editor #(
        .CAPACITY(CAP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .func        (func),
        .char_value  (char_value),
        .position    (position),
        .replace_char(replace_char),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .cursor_pos  (cursor_pos),
        .after_count (after_count),
        .char_before (char_before),
        .char_after  (char_after)
    );

    gap_buffer_text_editor_checker #(
        .CAPACITY(CAP)
    ) edit_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .func          (func),
        .char_value    (char_value),
        .position      (position),
        .replace_char  (replace_char),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .cursor_pos    (cursor_pos),
        .after_count   (after_count),
        .char_before   (char_before),
        .char_after    (char_after),
        .mismatch_count(mismatch_count),
        .views_pending (views_pending),
        .text_length   (text_length),
        .cursor_at     (cursor_at)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ends the run when no transaction moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("gap_buffer_text_editor_tb: errors");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] pick_char();
        // mostly a small alphabet so that replace finds matches
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3: return CHAR_W'($urandom_range(255));
            default: return 8'h61 + CHAR_W'($urandom_range(3));
        endcase
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // one command transaction, entered and left just after a falling edge
    task automatic issue_command(input logic [FUNC_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                 input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] repl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        func         <= op;
        char_value   <= ch;
        position     <= pos;
        replace_char <= repl;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random edit that keeps the line around len_cap characters
    task automatic random_edit(input int len_cap);
        int                len;
        int                roll;
        int                ins_w;
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  pos;
        len = text_length;
        ins_w = (len < len_cap) ? 40 : 8;
        roll = $urandom_range(99);
        if (roll < ins_w)
            op = FUNC_INSERT;
        else if (roll < ins_w + 20)
            op = FUNC_MOVE;
        else if (roll < ins_w + 28)
            op = FUNC_REPLACE;
        else if (roll[0])
            op = FUNC_DELETE;
        else
            op = FUNC_BACKSPACE;
        if (op == FUNC_MOVE && len < CAP && $urandom_range(9) == 0)
            pos = POS_W'($urandom_range(CAP, len + 1));
        else if (op == FUNC_MOVE)
            pos = POS_W'($urandom_range(len, 0));
        else
            pos = POS_W'($urandom_range(CAP, 0));
        issue_command(op, pick_char(), pos, pick_char());
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        func         = FUNC_INSERT;
        char_value   = '0;
        position     = '0;
        replace_char = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty line: errors, move to current position, replace on nothing
        issue_command(FUNC_BACKSPACE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_DELETE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd1, 8'h00);
        issue_command(FUNC_MOVE, 8'hFF, 11'd1024, 8'hFF);
        issue_command(FUNC_REPLACE, 8'h41, 11'd0, 8'h42);

        // short line with extreme characters, then walk the cursor, replace, delete and unused codes
        issue_command(FUNC_INSERT, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_INSERT, 8'hFF, 11'd0, 8'h00);
        issue_command(FUNC_INSERT, 8'h41, 11'd1023, 8'hFF);
        issue_command(FUNC_INSERT, 8'h41, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd2, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd2, 8'h00);
        issue_command(FUNC_REPLACE, 8'h41, 11'd0, 8'h7E);
        issue_command(FUNC_REPLACE, 8'hFF, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd1023, 8'h00);
        issue_command(FUNC_DELETE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_BACKSPACE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd5, 8'h00);
        issue_command(FUNC_SPARE_5, 8'h41, 11'd3, 8'h42);
        issue_command(FUNC_SPARE_6, 8'hFF, 11'd0, 8'hFF);
        issue_command(FUNC_SPARE_7, 8'h00, 11'd1024, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd2, 8'h00);
        issue_command(FUNC_DELETE, 8'h00, 11'd0, 8'h00);

        // random editing on short lines under each idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(56, 0);
                2: set_idling(0, 56);
                default: set_idling(8, 8);
            endcase
            // long result hold-off while commands keep coming
            if (phase == 0)
                hold_pending = 1'b1;
            repeat (PHASE_ITEMS) random_edit((phase == 0) ? 6 : 32);
        end

        // fill the line to capacity with occasional cursor moves
        set_idling(8, 8);
        while (text_length < CAP)
        begin
            if ($urandom_range(19) == 0)
                issue_command(FUNC_MOVE, pick_char(), POS_W'($urandom_range(text_length, 0)),
                              pick_char());
            else
                issue_command(FUNC_INSERT, pick_char(), POS_W'($urandom_range(CAP, 0)),
                              pick_char());
        end

        // full line: refused inserts, cursor at both ends, replace 8'h61 throughout, then edits
        issue_command(FUNC_INSERT, 8'h55, 11'd0, 8'h00);
        issue_command(FUNC_MOVE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_INSERT, 8'hAA, 11'd0, 8'h00);
        issue_command(FUNC_REPLACE, 8'h61, 11'd0, 8'hFF);
        issue_command(FUNC_MOVE, 8'h00, 11'd1024, 8'h00);
        issue_command(FUNC_DELETE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_BACKSPACE, 8'h00, 11'd0, 8'h00);
        issue_command(FUNC_INSERT, 8'hFF, 11'd0, 8'h00);
        issue_command(FUNC_INSERT, 8'h00, 11'd0, 8'h00);
        repeat (40) random_edit(CAP);

        cmd_valid <= 1'b0;
        wait (views_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && views_pending == 0)
            $display("gap_buffer_text_editor_tb: clean");
        else
            $display("gap_buffer_text_editor_tb: errors");
        $finish;
    end

endmodule
